// ===== design/velocity_command_watchdog_top_assert.svh =====
// Assertion macros shared by the watchdog checker.
`ifndef VELOCITY_COMMAND_WATCHDOG_TOP_ASSERT_SVH
`define VELOCITY_COMMAND_WATCHDOG_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, held off in reset
`define VCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("velocity watchdog check failed");

// Next-cycle implication, sampled on the rising edge, held off in reset
`define VCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("velocity watchdog check failed");

`endif

// ===== design/vcw_pkg.sv =====
package vcw_pkg;

  // Width of the saturating millisecond counter
  localparam int ELAPSED_BITS = 16;
  // Common width for comparing the counter with the 16-bit limits
  localparam int CMP_BITS = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_TOP = '1;

  localparam int SPEED_BITS = 16;
  localparam int DIV_STEPS  = 16;
  localparam logic [3:0] DIV_LAST_STEP = 4'd15;
  localparam logic [3:0] RECOVERY_TOP  = 4'd15;

  // Input command codes
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HOLD_MS      = 2'd0;
  localparam logic [1:0] REG_STOP_MS      = 2'd1;
  localparam logic [1:0] REG_GAP_MS       = 2'd2;
  localparam logic [1:0] REG_FRAMES_NEED  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] HOLD_MS_RST     = 16'd300;
  localparam logic [15:0] STOP_MS_RST     = 16'd800;
  localparam logic [15:0] GAP_MS_RST      = 16'd100;
  localparam logic [3:0]  FRAMES_NEED_RST = 4'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic div_step;
    logic div_last;
    logic lane;
    logic put;
  } vcw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ramp_go;
    logic out_free;
  } vcw_status_t;

endpackage

// ===== design/vcw_ctrl.sv =====
module vcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vcw_pkg::vcw_status_t status,
  output vcw_pkg::vcw_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [3:0] step;
  logic       lane;

  assign in_ready = (state == S_IDLE);

  // Decode state into datapath commands and pick the next state
  always_comb begin
    cmd        = '0;
    cmd.lane   = lane;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.ramp_go ? S_MUL : S_PUT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (step == vcw_pkg::DIV_LAST_STEP);
        if (cmd.div_last) begin
          state_next = lane ? S_PUT : S_MUL;
        end
      end
      S_PUT: begin
        cmd.put = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state, divider step count and lane
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      lane  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.eval) begin
        lane <= 1'b0;
      end
      if (cmd.mul) begin
        step <= '0;
      end else if (cmd.div_step) begin
        step <= step + 4'd1;
        if (cmd.div_last) begin
          lane <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/vcw_dp.sv =====
module vcw_dp (
  input  logic                clk,
  input  logic                rst,
  input  vcw_pkg::vcw_cmd_t   cmd,
  output vcw_pkg::vcw_status_t status,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          command,
  input  logic                running,
  input  logic signed [15:0]  linear_speed,
  input  logic signed [15:0]  angular_speed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                drive_update,
  output logic signed [15:0]  drive_linear,
  output logic signed [15:0]  drive_angular,
  output logic                stop_event,
  output logic                rejected
);

  localparam int EB = vcw_pkg::ELAPSED_BITS;
  localparam int CB = vcw_pkg::CMP_BITS;

  // Configuration
  logic [15:0] hold_ms;
  logic [15:0] stop_ms;
  logic [15:0] gap_ms;
  logic [3:0]  frames_need;

  // Watchdog state
  logic          mode_active;
  logic          stopped_flag;
  logic [3:0]    recovery_count;
  logic [EB-1:0] elapsed_count;
  logic [15:0]   held_linear;
  logic [15:0]   held_angular;

  // Latched input beat
  logic [1:0]  in_command;
  logic        in_running;
  logic [15:0] in_linear;
  logic [15:0] in_angular;

  // Result under construction
  logic        res_upd;
  logic [15:0] res_lin;
  logic [15:0] res_ang;
  logic        res_stop;
  logic        res_rej;

  // Ramp arithmetic
  logic [15:0] num;
  logic [15:0] den;
  logic [15:0] rem;
  logic [15:0] dq;
  logic        neg;

  logic [EB-1:0] elapsed_inc;
  logic [CB-1:0] e_ext;
  logic [CB-1:0] einc_ext;
  logic [CB-1:0] hold_ext;
  logic [CB-1:0] stop_ext;
  logic [CB-1:0] gap_ext;
  logic [CB-1:0] num_ext;
  logic [3:0]    rc_next;
  logic          is_frame;
  logic          is_tick;
  logic          recovering;
  logic          resume;
  logic          frame_upd;
  logic          watch_on;
  logic          ramp_go;
  logic          stop_go;

  logic [15:0] held_sel;
  logic [16:0] mag;
  logic [32:0] prod_w;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  logic [15:0] rem_new;
  logic [15:0] dq_new;
  logic [15:0] q_signed;

  // Decide the item's effect from the latched beat and current state
  always_comb begin
    elapsed_inc = (elapsed_count == vcw_pkg::ELAPSED_TOP) ? elapsed_count
                                                          : elapsed_count + 1'b1;
    e_ext      = CB'(elapsed_count);
    einc_ext   = CB'(elapsed_inc);
    hold_ext   = CB'(hold_ms);
    stop_ext   = CB'(stop_ms);
    gap_ext    = CB'(gap_ms);
    num_ext    = stop_ext - einc_ext;
    is_frame   = (in_command == vcw_pkg::CMD_FRAME);
    is_tick    = (in_command == vcw_pkg::CMD_TICK);
    recovering = mode_active && stopped_flag;
    if ((recovery_count != 4'd0) && (e_ext <= gap_ext)) begin
      rc_next = (recovery_count < vcw_pkg::RECOVERY_TOP) ? recovery_count + 4'd1
                                                         : recovery_count;
    end else begin
      rc_next = 4'd1;
    end
    resume    = rc_next >= frames_need;
    frame_upd = is_frame && in_running && (!recovering || resume);
    watch_on  = is_tick && mode_active && !stopped_flag && in_running &&
                (einc_ext > hold_ext);
    ramp_go   = watch_on && (einc_ext < stop_ext);
    stop_go   = watch_on && (einc_ext >= stop_ext);
  end

  assign status.ramp_go  = ramp_go;
  assign status.out_free = !out_valid || out_ready;

  // Magnitude times remaining span, then one restoring divide step a cycle
  always_comb begin
    held_sel = cmd.lane ? held_angular : held_linear;
    mag      = held_sel[15] ? (17'd0 - {held_sel[15], held_sel}) : {1'b0, held_sel};
    prod_w   = 33'(mag) * 33'(num);
    trial    = {rem, dq[15]};
    ge       = trial >= {1'b0, den};
    diff     = trial - {1'b0, den};
    rem_new  = ge ? diff[15:0] : trial[15:0];
    dq_new   = {dq[14:0], ge};
    q_signed = neg ? (16'd0 - dq_new) : dq_new;
  end

  // Configuration writes and watchdog state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms        <= vcw_pkg::HOLD_MS_RST;
      stop_ms        <= vcw_pkg::STOP_MS_RST;
      gap_ms         <= vcw_pkg::GAP_MS_RST;
      frames_need    <= vcw_pkg::FRAMES_NEED_RST;
      mode_active    <= 1'b0;
      stopped_flag   <= 1'b0;
      recovery_count <= '0;
      elapsed_count  <= '0;
      held_linear    <= '0;
      held_angular   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          vcw_pkg::REG_HOLD_MS:     hold_ms     <= cfg_data;
          vcw_pkg::REG_STOP_MS:     stop_ms     <= cfg_data;
          vcw_pkg::REG_GAP_MS:      gap_ms      <= cfg_data;
          vcw_pkg::REG_FRAMES_NEED: frames_need <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        case (in_command)
          vcw_pkg::CMD_FRAME: begin
            if (in_running) begin
              elapsed_count <= '0;
              held_linear   <= in_linear;
              held_angular  <= in_angular;
              if (recovering) begin
                if (resume) begin
                  stopped_flag   <= 1'b0;
                  recovery_count <= '0;
                end else begin
                  recovery_count <= rc_next;
                end
              end else begin
                mode_active    <= 1'b1;
                recovery_count <= '0;
              end
            end
          end
          vcw_pkg::CMD_TICK: begin
            elapsed_count <= elapsed_inc;
            if (stop_go) begin
              stopped_flag   <= 1'b1;
              recovery_count <= '0;
            end
          end
          vcw_pkg::CMD_CLEAR: begin
            mode_active    <= 1'b0;
            stopped_flag   <= 1'b0;
            recovery_count <= '0;
            elapsed_count  <= '0;
            held_linear    <= '0;
            held_angular   <= '0;
          end
          default: ;
        endcase
      end
      out_valid <= cmd.put || (out_valid && !out_ready);
    end
  end

  // Input latch, result build, ramp arithmetic and output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_command <= command;
      in_running <= running;
      in_linear  <= linear_speed;
      in_angular <= angular_speed;
    end
    if (cmd.eval) begin
      res_upd  <= frame_upd || watch_on;
      res_lin  <= frame_upd ? in_linear  : 16'd0;
      res_ang  <= frame_upd ? in_angular : 16'd0;
      res_stop <= stop_go;
      res_rej  <= is_frame && !in_running;
      num      <= num_ext[15:0];
      den      <= stop_ms - hold_ms;
    end
    if (cmd.mul) begin
      rem <= prod_w[31:16];
      dq  <= prod_w[15:0];
      neg <= held_sel[15];
    end
    if (cmd.div_step) begin
      rem <= rem_new;
      dq  <= dq_new;
      if (cmd.div_last) begin
        if (cmd.lane) begin
          res_ang <= q_signed;
        end else begin
          res_lin <= q_signed;
        end
      end
    end
    if (cmd.put) begin
      drive_update  <= res_upd;
      drive_linear  <= res_lin;
      drive_angular <= res_ang;
      stop_event    <= res_stop;
      rejected      <= res_rej;
    end
  end

endmodule

// ===== design/velocity_command_watchdog_top.sv =====
// Velocity command watchdog. Each input beat is a velocity frame, a one
// millisecond tick or a clear, and each gives exactly one result beat. Frames
// and non-ramp ticks go from acceptance through the evaluate state and the
// put state into the output register. A ramp tick also runs the ramp
// arithmetic between those two states: one shared 17x16 multiplier followed
// by a 16-step restoring divider, run once for the linear and once for the
// angular lane. One item is worked on at a time; the next is taken once
// the result has moved into the output register, where it waits for
// out_ready. Configuration writes are taken every cycle and must only be
// made while the block is idle.
module velocity_command_watchdog_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic               running,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] angular_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               drive_update,
  output logic signed [15:0] drive_linear,
  output logic signed [15:0] drive_angular,
  output logic               stop_event,
  output logic               rejected
);

  vcw_pkg::vcw_cmd_t    cmd;
  vcw_pkg::vcw_status_t status;

  assign cfg_ready = 1'b1;

  vcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vcw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .running       (running),
    .linear_speed  (linear_speed),
    .angular_speed (angular_speed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_update  (drive_update),
    .drive_linear  (drive_linear),
    .drive_angular (drive_angular),
    .stop_event    (stop_event),
    .rejected      (rejected)
  );

endmodule

// ===== design/vcw_checker.sv =====
`include "velocity_command_watchdog_top_assert.svh"

module vcw_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               drive_update,
  input logic signed [15:0] drive_linear,
  input logic signed [15:0] drive_angular,
  input logic               stop_event,
  input logic               rejected
);

  // Hold a stalled result beat valid with its speeds steady
  `VCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_linear) && $stable(drive_angular))

  // Drop input ready for the cycle after a beat is taken
  `VCW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // No speed without an update, and a stop applies zero speed
  `VCW_ASSERT_NOW(a_zero_idle, out_valid && (!drive_update || stop_event), drive_linear == 16'sd0 && drive_angular == 16'sd0)

  // A rejected frame neither drives nor stops
  `VCW_ASSERT_NOW(a_reject_quiet, out_valid && rejected, !drive_update && !stop_event)

endmodule

bind velocity_command_watchdog_top vcw_checker u_vcw_checker (.*);

// ===== dv/tb_velocity_command_watchdog_top.sv =====
module tb_velocity_command_watchdog_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RUN_LIMIT    = 3_000_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               run;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
  } vel_beat_t;

  typedef struct packed {
    logic               upd;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic               stop;
    logic               rej;
  } drive_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = vcw_pkg::REG_HOLD_MS;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = vcw_pkg::CMD_TICK;
  logic               running = 1'b0;
  logic signed [15:0] linear_speed = '0;
  logic signed [15:0] angular_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               drive_update;
  logic signed [15:0] drive_linear;
  logic signed [15:0] drive_angular;
  logic               stop_event;
  logic               rejected;

  velocity_command_watchdog_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .running      (running),
    .linear_speed (linear_speed),
    .angular_speed(angular_speed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_update (drive_update),
    .drive_linear (drive_linear),
    .drive_angular(drive_angular),
    .stop_event   (stop_event),
    .rejected     (rejected)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vel_beat_t  beat_queue[$];
  drive_out_t drive_expected[$];
  vel_beat_t  staged;
  logic       in_took = 1'b0;
  logic       idle_on = 1'b0;
  int         send_hold = 0;
  int         sink_hold = 0;
  int         queued_items = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  // Watchdog limits as last written, and the watchdog state
  logic [15:0]                      hold_lim;
  logic [15:0]                      stop_lim;
  logic [15:0]                      gap_lim;
  logic [3:0]                       frames_need;
  logic                             wd_active;
  logic                             wd_stopped;
  logic [3:0]                       wd_recovery;
  logic [vcw_pkg::ELAPSED_BITS-1:0] wd_elapsed;
  logic signed [15:0]               held_lin;
  logic signed [15:0]               held_ang;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("t=%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_watchdog_state();
    wd_active   = 1'b0;
    wd_stopped  = 1'b0;
    wd_recovery = '0;
    wd_elapsed  = '0;
    held_lin    = '0;
    held_ang    = '0;
  endfunction

  // Scale a held speed by num/den, exact product, division truncating to zero
  function automatic logic signed [15:0] ramp_speed(logic signed [15:0] held, int num,
                                                    int den);
    longint prod;
    prod = longint'(held) * longint'(num);
    return 16'(prod / longint'(den));
  endfunction

  // Advance the watchdog by one accepted beat and return the drive it causes
  function automatic drive_out_t predict_drive(vel_beat_t b);
    drive_out_t r;
    r = '0;
    case (b.cmd)
      vcw_pkg::CMD_FRAME: begin
        if (!b.run) begin
          r.rej = 1'b1;
        end else if (wd_active && wd_stopped) begin
          // count close recovery frames, restart the count after a long gap
          if (wd_recovery != 4'd0 && wd_elapsed <= gap_lim) begin
            if (wd_recovery != vcw_pkg::RECOVERY_TOP) wd_recovery = wd_recovery + 4'd1;
          end else begin
            wd_recovery = 4'd1;
          end
          wd_elapsed = '0;
          held_lin   = b.lin;
          held_ang   = b.ang;
          if (wd_recovery >= frames_need) begin
            wd_stopped  = 1'b0;
            wd_recovery = '0;
            r.upd       = 1'b1;
            r.lin       = held_lin;
            r.ang       = held_ang;
          end
        end else begin
          wd_active   = 1'b1;
          wd_recovery = '0;
          wd_elapsed  = '0;
          held_lin    = b.lin;
          held_ang    = b.ang;
          r.upd       = 1'b1;
          r.lin       = held_lin;
          r.ang       = held_ang;
        end
      end
      vcw_pkg::CMD_TICK: begin
        if (wd_elapsed != vcw_pkg::ELAPSED_TOP) wd_elapsed = wd_elapsed + 1'b1;
        if (wd_active && !wd_stopped && b.run && wd_elapsed > hold_lim) begin
          r.upd = 1'b1;
          if (wd_elapsed < stop_lim) begin
            r.lin = ramp_speed(held_lin, int'(stop_lim) - int'(wd_elapsed),
                               int'(stop_lim) - int'(hold_lim));
            r.ang = ramp_speed(held_ang, int'(stop_lim) - int'(wd_elapsed),
                               int'(stop_lim) - int'(hold_lim));
          end else begin
            r.stop      = 1'b1;
            wd_stopped  = 1'b1;
            wd_recovery = '0;
          end
        end
      end
      vcw_pkg::CMD_CLEAR: clear_watchdog_state();
      default: ;
    endcase
    return r;
  endfunction

  // Sample both channels: check returned drives, predict for taken beats
  always @(posedge clk) begin
    drive_out_t got;
    drive_out_t want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = {drive_update, drive_linear, drive_angular, stop_event, rejected};
        if (drive_expected.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = drive_expected.pop_front();
          if (got.upd !== want.upd)
            report_mismatch($sformatf("drive_update %b, want %b", got.upd, want.upd));
          if (got.lin !== want.lin)
            report_mismatch($sformatf("drive_linear %0d, want %0d", got.lin, want.lin));
          if (got.ang !== want.ang)
            report_mismatch($sformatf("drive_angular %0d, want %0d", got.ang, want.ang));
          if (got.stop !== want.stop)
            report_mismatch($sformatf("stop_event %b, want %b", got.stop, want.stop));
          if (got.rej !== want.rej)
            report_mismatch($sformatf("rejected %b, want %b", got.rej, want.rej));
        end
      end
      if (in_valid && in_ready)
        drive_expected.push_back(predict_drive('{command, running, linear_speed,
                                                 angular_speed}));
    end
  end

  // Present the next pending beat once the previous one has gone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_hold != 0) begin
        send_hold--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_hold = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (beat_queue.size() != 0) begin
        staged = beat_queue.pop_front();
        command       <= staged.cmd;
        running       <= staged.run;
        linear_speed  <= staged.lin;
        angular_speed <= staged.ang;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      sink_hold = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic wait_for_drain();
    while (beat_queue.size() != 0 || in_valid || drive_expected.size() != 0)
      @(posedge clk);
  endtask

  // Write all four limits back to back, mirroring each as it is taken
  task automatic write_limits(input logic [15:0] hold, input logic [15:0] stop,
                              input logic [15:0] gap, input logic [3:0] need);
    logic [15:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{hold, stop, gap, {12'($urandom), need}};
    idx  = '{vcw_pkg::REG_HOLD_MS, vcw_pkg::REG_STOP_MS, vcw_pkg::REG_GAP_MS,
             vcw_pkg::REG_FRAMES_NEED};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        vcw_pkg::REG_HOLD_MS:     hold_lim    = vals[i];
        vcw_pkg::REG_STOP_MS:     stop_lim    = vals[i];
        vcw_pkg::REG_GAP_MS:      gap_lim     = vals[i];
        vcw_pkg::REG_FRAMES_NEED: frames_need = vals[i][3:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short limits so ramps and stops are reached, now and then the extremes
  task automatic write_random_limits();
    logic [15:0] hold;
    logic [15:0] stop;
    logic [15:0] gap;
    logic [3:0]  need;
    case ($urandom_range(0, 9))
      0:       hold = 16'd0;
      1:       hold = 16'hFFFF;
      default: hold = 16'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       stop = 16'd0;
      1:       stop = 16'hFFFF;
      2:       stop = hold;
      3:       stop = 16'($urandom_range(0, int'(hold)));
      default: stop = (hold > 16'hFFF0) ? 16'hFFFF : hold + 16'($urandom_range(1, 15));
    endcase
    case ($urandom_range(0, 9))
      0:       gap = 16'd0;
      1:       gap = 16'hFFFF;
      default: gap = 16'($urandom_range(0, 6));
    endcase
    need = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
    write_limits(hold, stop, gap, need);
  endtask

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_beat(logic [1:0] cmd, logic run, logic signed [15:0] lin,
                                    logic signed [15:0] ang);
    beat_queue.push_back('{cmd, run, lin, ang});
    if (cmd != CMD_UNUSED) queued_items++;
  endfunction

  // One millisecond of silence, sometimes with a stray beat in front
  function automatic void push_quiet_ms();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0:       push_beat(vcw_pkg::CMD_CLEAR, 1'($urandom), rand_speed(), rand_speed());
        1, 2:    push_beat(vcw_pkg::CMD_FRAME, 1'b0, rand_speed(), rand_speed());
        3:       push_beat(CMD_UNUSED, 1'($urandom), rand_speed(), rand_speed());
        default: push_beat(vcw_pkg::CMD_TICK, 1'b0, rand_speed(), rand_speed());
      endcase
    end
    push_beat(vcw_pkg::CMD_TICK, $urandom_range(0, 9) != 0, rand_speed(), rand_speed());
  endfunction

  // Fresh command, silence through the ramp into the stop, then recovery frames
  task automatic queue_episode();
    int tick_span;
    int gap_span;
    int frames;
    tick_span = (stop_lim > 16'd40) ? 40 : int'(stop_lim);
    gap_span  = (gap_lim > 16'd6) ? 6 : int'(gap_lim);
    frames    = $urandom_range(1, int'(frames_need) + 2);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, rand_speed(), rand_speed());
    repeat ($urandom_range(0, tick_span + 3)) push_quiet_ms();
    repeat (frames) begin
      repeat ($urandom_range(0, gap_span + 2)) push_quiet_ms();
      push_beat(vcw_pkg::CMD_FRAME, $urandom_range(0, 11) != 0, rand_speed(), rand_speed());
    end
  endtask

  // Give up on a hung run
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase_end;
    hold_lim    = vcw_pkg::HOLD_MS_RST;
    stop_lim    = vcw_pkg::STOP_MS_RST;
    gap_lim     = vcw_pkg::GAP_MS_RST;
    frames_need = vcw_pkg::FRAMES_NEED_RST;
    clear_watchdog_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Reset limits: rejection, extreme speeds, a quiet tick, clear, unused code
    push_beat(vcw_pkg::CMD_FRAME, 1'b0, 16'sh7FFF, 16'sh8000);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh7FFF, 16'sh8000);
    push_beat(vcw_pkg::CMD_TICK, 1'b1, 16'sh0000, 16'shFFFF);
    push_beat(CMD_UNUSED, 1'b1, 16'shFFFF, 16'sh0000);
    push_beat(vcw_pkg::CMD_CLEAR, 1'b1, 16'sh5A5A, 16'shA5A5);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh8000, 16'sh7FFF);
    wait_for_drain();

    // Short ramp, stop, a broken recovery and then a good one
    write_limits(16'd2, 16'd5, 16'd1, 4'd2);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh8000, 16'sh7FFF);
    push_beat(vcw_pkg::CMD_TICK, 1'b0, 16'sh0000, 16'sh0000);
    repeat (5) push_beat(vcw_pkg::CMD_TICK, 1'b1, 16'sh1234, 16'shFEDC);
    push_beat(vcw_pkg::CMD_FRAME, 1'b0, 16'sh0100, 16'sh0200);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh0100, 16'sh0200);
    repeat (2) push_beat(vcw_pkg::CMD_TICK, 1'b1, 16'sh0000, 16'sh0000);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh0300, -16'sh0400);
    push_beat(vcw_pkg::CMD_TICK, 1'b1, 16'sh0000, 16'sh0000);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, -16'sh0500, 16'sh0600);
    wait_for_drain();

    // Zero limits: stop on the first tick, resume on the next frame
    write_limits(16'd0, 16'd0, 16'd0, 4'd0);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh0042, -16'sh0042);
    push_beat(vcw_pkg::CMD_TICK, 1'b1, 16'sh0000, 16'sh0000);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh0077, 16'sh0011);
    wait_for_drain();

    // Top limits: the watchdog never acts
    write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    push_beat(vcw_pkg::CMD_FRAME, 1'b1, 16'sh7FFF, 16'sh7FFF);
    push_beat(vcw_pkg::CMD_TICK, 1'b1, 16'sh8000, 16'sh8000);
    wait_for_drain();

    // Random episodes, new limits each phase, sender paused at each boundary
    while (queued_items < RANDOM_ITEMS) begin
      write_random_limits();
      idle_on   = $urandom_range(0, 3) != 0;
      phase_end = queued_items + 60;
      while (queued_items < phase_end) queue_episode();
      wait_for_drain();
    end

    // Closing stretch at full rate
    idle_on = 1'b0;
    write_random_limits();
    phase_end = queued_items + 80;
    while (queued_items < phase_end) queue_episode();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
